// ===== design/time_date_set_editor_defines.svh =====
// ----------------------------------------------------------------------------
// Time/date set editor - assertion macros
// Clocked assertion wrappers used by the editor top level.
// ----------------------------------------------------------------------------
`ifndef TIME_DATE_SET_EDITOR_DEFINES_SVH
`define TIME_DATE_SET_EDITOR_DEFINES_SVH

// checked on every rising edge outside reset
`define TDE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tde assertion failed");

// checked on every rising edge, reset included
`define TDE_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("tde assertion failed");

`endif

// ===== design/tde_pkg.sv =====
// ----------------------------------------------------------------------------
// tde_pkg
// Types, codes and calendar/digit helpers for the time/date set editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tde_pkg;

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_PRESS  = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_COMMIT = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   localparam logic [1:0]  PAGE_TIME   = 2'd0;
   localparam logic [1:0]  PAGE_YEAR   = 2'd1;
   localparam logic [1:0]  PAGE_DATE   = 2'd2;
   localparam logic [1:0]  FIELD_LEFT  = 2'd0;
   localparam logic [1:0]  FIELD_RIGHT = 2'd2;

   localparam logic [4:0]  HOUR_MAX    = 5'd23;
   localparam logic [5:0]  MINUTE_MAX  = 6'd59;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [3:0]  MONTH_MAX   = 4'd12;
   localparam logic [4:0]  DAYS_LONG   = 5'd31;
   localparam logic [4:0]  DAYS_SHORT  = 5'd30;
   localparam logic [4:0]  DAYS_FEB    = 5'd28;
   localparam logic [4:0]  DAYS_LEAP   = 5'd29;
   localparam logic [3:0]  BLANK_CODE  = 4'd12;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  direction;
      logic [4:0]  cur_hour;
      logic [5:0]  cur_minute;
      logic [13:0] cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
   } tde_req_type;

   typedef struct packed {
      logic [3:0]  shown_digit0;
      logic [3:0]  shown_digit1;
      logic [3:0]  shown_digit2;
      logic [3:0]  shown_digit3;
      logic        colon_on;
      logic [1:0]  page_now;
      logic [1:0]  field_now;
      logic [4:0]  set_hour;
      logic [5:0]  set_minute;
      logic [13:0] set_year;
      logic [3:0]  set_month;
      logic        commit_valid;
   } tde_rsp_type;

   typedef struct packed {
      logic             editing;
      logic [1:0]       page;
      logic [1:0]       field_sel;
      logic             blink;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [13:0]      year;
      logic [3:0]       month;
      logic [4:0]       day;
      logic [3:0][3:0]  digits;
   } tde_state_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
      logic [4:0] n;
      case (m)
         4'd2:                     n = (y[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
         4'd4, 4'd6, 4'd9, 4'd11:  n = DAYS_SHORT;
         default:                  n = DAYS_LONG;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] month_wrap(input logic [3:0] m);
      logic [3:0] r;
      if (m == 4'd0) r = MONTH_MAX;
      else if (m > MONTH_MAX) r = 4'd1;
      else r = m;
      return r;
   endfunction

   function automatic logic [4:0] day_wrap(input logic [5:0] d, input logic [3:0] m,
                                           input logic [13:0] y);
      logic [4:0] n;
      logic [4:0] r;
      n = month_len(m, y);
      if (d == 6'd0) r = n;
      else if (d > {1'b0, n}) r = 5'd1;
      else r = d[4:0];
      return r;
   endfunction

   // tens/units of a value below 64: tens = (v * 13) >> 7
   function automatic logic [7:0] pair_digits(input logic [5:0] v);
      logic [9:0] prod;
      logic [3:0] tens;
      logic [5:0] rem;
      prod = v * 4'd13;
      tens = {1'b0, prod[9:7]};
      rem  = v - 6'(tens * 4'd10);
      return {tens, rem[3:0]};
   endfunction

   // four decimal digits of a year up to 9999, reciprocal multiplies
   function automatic logic [15:0] year_digits(input logic [13:0] y);
      logic [29:0] p10;
      logic [26:0] p100;
      logic [28:0] p1000;
      logic [9:0]  q10;
      logic [6:0]  q100;
      logic [3:0]  q1000;
      logic [13:0] r0;
      logic [9:0]  r1;
      logic [6:0]  r2;
      p10   = y * 16'd52429;
      p100  = y * 13'd5243;
      p1000 = y * 15'd16778;
      q10   = p10[28:19];
      q100  = p100[25:19];
      q1000 = p1000[27:24];
      r0    = y - 14'(q10 * 4'd10);
      r1    = q10 - 10'(q100 * 4'd10);
      r2    = q100 - 7'(q1000 * 4'd10);
      return {r0[3:0], r1[3:0], r2[3:0], q1000};
   endfunction

endpackage

`default_nettype wire

// ===== design/tde_step.sv =====
// ----------------------------------------------------------------------------
// tde_step
// Next editor state for one request: load, press, blink toggle and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tde_step (
   input  tde_pkg::tde_state_type cur,
   input  tde_pkg::tde_req_type   req,
   output tde_pkg::tde_state_type nxt,
   output logic                   committed
);
   import tde_pkg::*;

   logic        redraw;
   logic [3:0]  month_t;
   logic [5:0]  day_t;
   logic        up;
   logic [7:0]  pair_l;
   logic [7:0]  pair_r;
   logic [15:0] ydig;

   always_comb begin
      nxt       = cur;
      committed = 1'b0;
      redraw    = 1'b0;
      month_t   = cur.month;
      day_t     = {1'b0, cur.day};
      up        = (req.direction == DIR_UP);
      unique case (req.req_type)
         REQ_START: begin
            if (!cur.editing) begin
               nxt.editing = 1'b1;
               nxt.page    = PAGE_TIME;
               nxt.hour    = (req.cur_hour > HOUR_MAX) ? HOUR_MAX : req.cur_hour;
               nxt.minute  = (req.cur_minute > MINUTE_MAX) ? 6'd0 : req.cur_minute;
               nxt.year    = (req.cur_year > YEAR_MAX) ? YEAR_MAX : req.cur_year;
               month_t     = req.cur_month;
               day_t       = {1'b0, req.cur_day};
               redraw      = 1'b1;
            end
         end
         REQ_PRESS: begin
            if (cur.editing) begin
               redraw = 1'b1;
               case (req.direction) inside
                  DIR_UP, DIR_DOWN: begin
                     if (cur.page == PAGE_TIME) begin
                        if (cur.field_sel == FIELD_LEFT) begin
                           if (up && cur.hour < HOUR_MAX) nxt.hour = cur.hour + 5'd1;
                           else if (!up && cur.hour != 5'd0) nxt.hour = cur.hour - 5'd1;
                        end else if (cur.field_sel == FIELD_RIGHT) begin
                           if (up) nxt.minute = (cur.minute >= MINUTE_MAX) ? 6'd0
                                                : cur.minute + 6'd1;
                           else nxt.minute = (cur.minute == 6'd0) ? MINUTE_MAX
                                             : cur.minute - 6'd1;
                        end
                     end else if (cur.page == PAGE_YEAR) begin
                        if (up && cur.year < YEAR_MAX) nxt.year = cur.year + 14'd1;
                        else if (!up && cur.year != 14'd0) nxt.year = cur.year - 14'd1;
                     end else begin
                        if (cur.field_sel == FIELD_LEFT) begin
                           month_t = up ? cur.month + 4'd1 : cur.month - 4'd1;
                        end else if (cur.field_sel == FIELD_RIGHT) begin
                           day_t = up ? {1'b0, cur.day} + 6'd1 : {1'b0, cur.day} - 6'd1;
                        end
                     end
                  end
                  DIR_RIGHT: begin
                     if (cur.page == PAGE_TIME) begin
                        if (cur.field_sel == FIELD_RIGHT) nxt.page = PAGE_YEAR;
                        nxt.field_sel = FIELD_RIGHT;
                     end else if (cur.page == PAGE_YEAR) begin
                        nxt.page      = PAGE_DATE;
                        nxt.field_sel = FIELD_LEFT;
                     end else begin
                        nxt.field_sel = FIELD_RIGHT;
                     end
                  end
                  default: begin
                     if (cur.page == PAGE_TIME) begin
                        if (cur.field_sel == FIELD_RIGHT) nxt.field_sel = FIELD_LEFT;
                     end else if (cur.page == PAGE_YEAR) begin
                        nxt.page      = PAGE_TIME;
                        nxt.field_sel = FIELD_RIGHT;
                     end else if (cur.field_sel == FIELD_RIGHT) begin
                        nxt.field_sel = FIELD_LEFT;
                     end else begin
                        nxt.page      = PAGE_YEAR;
                        nxt.field_sel = FIELD_LEFT;
                     end
                  end
               endcase
            end
         end
         REQ_TICK: begin
            if (cur.editing) nxt.blink = ~cur.blink;
         end
         REQ_COMMIT: begin
            if (cur.editing) begin
               nxt.editing = 1'b0;
               committed   = 1'b1;
            end
         end
         default: ;
      endcase

      if (redraw) begin
         nxt.month = month_wrap(month_t);
         nxt.day   = day_wrap(day_t, nxt.month, nxt.year);
      end

      ydig = year_digits(nxt.year);
      if (nxt.page == PAGE_TIME) begin
         pair_l = pair_digits({1'b0, nxt.hour});
         pair_r = pair_digits(nxt.minute);
      end else begin
         pair_l = pair_digits({2'b00, nxt.month});
         pair_r = pair_digits({1'b0, nxt.day});
      end

      if (redraw) begin
         if (nxt.page == PAGE_YEAR) begin
            nxt.digits[0] = ydig[3:0];
            nxt.digits[1] = ydig[7:4];
            nxt.digits[2] = ydig[11:8];
            nxt.digits[3] = ydig[15:12];
         end else begin
            nxt.digits[0] = pair_l[7:4];
            nxt.digits[1] = pair_l[3:0];
            nxt.digits[2] = pair_r[7:4];
            nxt.digits[3] = pair_r[3:0];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/tde_show.sv =====
// ----------------------------------------------------------------------------
// tde_show
// Builds the result: blinked digits, commit view with day digits, values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tde_show (
   input  tde_pkg::tde_state_type st,
   input  logic                   committed,
   output tde_pkg::tde_rsp_type   rsp
);
   import tde_pkg::*;

   logic [3:0][3:0] d;
   logic [7:0]      day_pair;
   logic [1:0]      sel_hi;
   logic [1:0]      sel_lo;

   always_comb begin
      d        = st.digits;
      day_pair = pair_digits({1'b0, st.day});
      sel_hi   = {st.field_sel[1], 1'b0};
      sel_lo   = {st.field_sel[1], 1'b1};
      if (committed) begin
         d[0] = BLANK_CODE;
         d[1] = BLANK_CODE;
         d[2] = day_pair[7:4];
         d[3] = day_pair[3:0];
      end else if (st.editing) begin
         if (st.page == PAGE_YEAR) begin
            if (st.blink) begin
               d[0] = BLANK_CODE;
               d[2] = BLANK_CODE;
            end else begin
               d[1] = BLANK_CODE;
               d[3] = BLANK_CODE;
            end
         end else if (st.blink) begin
            d[sel_hi] = BLANK_CODE;
         end else begin
            d[sel_lo] = BLANK_CODE;
         end
      end

      rsp.shown_digit0 = d[0];
      rsp.shown_digit1 = d[1];
      rsp.shown_digit2 = d[2];
      rsp.shown_digit3 = d[3];
      rsp.colon_on     = (st.page == PAGE_TIME);
      rsp.page_now     = st.page;
      rsp.field_now    = st.field_sel;
      rsp.set_hour     = st.hour;
      rsp.set_minute   = st.minute;
      rsp.set_year     = st.year;
      rsp.set_month    = st.month;
      rsp.commit_valid = committed;
   end

endmodule

`default_nettype wire

// ===== design/time_date_set_editor.sv =====
// An accepted request waits in the input register until the result register is free.
// Throughput: one transfer per cycle; the input register and the result register
// decouple the two channels, so req_ready drops only when both hold data and
// the result is stalled.
// Reset: synchronous; clears both stages and returns the editor to idle,
// time page, month 1, day 1, all other values and digits zero.
// ----------------------------------------------------------------------------
// time_date_set_editor
// Button-driven time/date set editor with blinking four-digit view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "time_date_set_editor_defines.svh"

module time_date_set_editor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tde_pkg::tde_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tde_pkg::tde_rsp_type rsp_payload
);
   import tde_pkg::*;

   logic          in_valid_ff;
   tde_req_type   in_req_ff;
   tde_state_type state_ff;
   tde_state_type state_in;
   logic          committed;
   tde_rsp_type   rsp_in;
   tde_rsp_type   rsp_ff;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
   end

   tde_step u_step (
      .cur       (state_ff),
      .req       (in_req_ff),
      .nxt       (state_in),
      .committed (committed)
   );

   tde_show u_show (
      .st        (state_in),
      .committed (committed),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.editing   <= 1'b0;
         state_ff.page      <= PAGE_TIME;
         state_ff.field_sel <= FIELD_LEFT;
         state_ff.blink     <= 1'b0;
         state_ff.hour      <= 5'd0;
         state_ff.minute    <= 6'd0;
         state_ff.year      <= 14'd0;
         state_ff.month     <= 4'd1;
         state_ff.day       <= 5'd1;
         state_ff.digits    <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TDE_ASSERT(a_state_hold, !advance |=> $stable(state_ff))
   `TDE_ASSERT(a_year_range, state_ff.year <= YEAR_MAX)
   `TDE_ASSERT(a_commit_view,
      rsp_valid_ff && rsp_ff.commit_valid |-> !state_ff.editing &&
      rsp_ff.shown_digit0 == BLANK_CODE && rsp_ff.shown_digit1 == BLANK_CODE)
   `TDE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff && !in_valid_ff)

endmodule

`default_nettype wire
